// ===== rtl/lca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA query package
// Shared types, field widths and constants of the tree LCA distance unit.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;
  localparam int LVL_W   = 5;
  localparam int LIFT_W  = 21;
  localparam int SUM_W   = 13;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 11'd2047;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic               is_answer;
    logic [NODE_W-1:0]  ancestor;
    logic [DIST_W-1:0]  distance;
    logic [DEPTH_W-1:0] node_depth;
  } out_item_t;

  typedef enum logic [1:0] {
    ALU_INC_SAT,
    ALU_LIFT_GE,
    ALU_GT,
    ALU_DIST
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [DEPTH_W-1:0] x;
    logic [DEPTH_W-1:0] y;
    logic [DEPTH_W-1:0] z;
    logic [LVL_W-1:0]   lvl;
  } alu_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] res;
    logic              flag;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_CAP_A,
    S_CAP_B,
    S_ADD_DEP,
    S_ADD_INC,
    S_ADD_RD,
    S_ADD_WR,
    S_Q_DA,
    S_Q_DB,
    S_Q_SW,
    S_L1_CHK,
    S_L1_ANC,
    S_L1_DEP,
    S_L1_END,
    S_L2_RA,
    S_L2_RB,
    S_L2_CMP,
    S_L2_FIN,
    S_L2_PAR,
    S_Q_DC,
    S_Q_DIST,
    S_FIN
  } state_t;

endpackage

// ===== rtl/lca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lca_idx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA node index reduction
// Two-stage pipeline that reduces a node field modulo the node count.
// ----------------------------------------------------------------------------
module lca_idx import lca_pkg::*; #(
  parameter int NODES = 1024,
  localparam int IW = $clog2(NODES)
) (
  input  logic              clk,
  input  logic [NODE_W-1:0] raw,
  output logic [IW-1:0]     idx
);

  if ((NODES >= (1 << NODE_W)) || ((NODES & (NODES - 1)) == 0)) begin : g_plain
    logic [NODE_W-1:0] v1_r;
    logic [IW-1:0]     idx_r;

    always_ff @(posedge clk) begin
      v1_r  <= raw;
      idx_r <= IW'(v1_r);
    end

    assign idx = idx_r;
  end else begin : g_recip
    localparam int RECIP = (1 << 20) / NODES;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int QW    = NODE_W + RW - 20;
    localparam int PW    = 2 * NODE_W;
    localparam logic [NODE_W-1:0] NODES_V = NODE_W'(NODES);

    logic [NODE_W+RW-1:0] prod;
    logic [QW-1:0]        q_r;
    logic [NODE_W-1:0]    v1_r;
    logic [PW-1:0]        qn;
    logic [NODE_W-1:0]    rem;
    logic [NODE_W-1:0]    rem_fix;
    logic [IW-1:0]        idx_r;

    assign prod    = (NODE_W + RW)'(raw) * (NODE_W + RW)'(RECIP);
    assign qn      = PW'(q_r) * PW'(NODES);
    assign rem     = v1_r - qn[NODE_W-1:0];
    assign rem_fix = (rem >= NODES_V) ? (rem - NODES_V) : rem;

    always_ff @(posedge clk) begin
      q_r   <= prod[NODE_W+RW-1:20];
      v1_r  <= raw;
      idx_r <= IW'(rem_fix);
    end

    assign idx = idx_r;
  end

endmodule

// ===== rtl/lca_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA depth arithmetic unit
// Shared add and compare unit for depth increment, lift test and distance.
// ----------------------------------------------------------------------------
module lca_alu import lca_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [DIST_W-1:0] inc;
  logic [LIFT_W-1:0] thr;
  logic [SUM_W-1:0]  sum;

  assign inc = DIST_W'(req.x) + DIST_W'(1);
  assign thr = LIFT_W'(req.y) + (LIFT_W'(1) << req.lvl);
  assign sum = SUM_W'(req.x) + SUM_W'(req.y) - (SUM_W'(req.z) << 1);

  always_comb begin
    rsp.res  = '0;
    rsp.flag = 1'b0;
    unique case (req.op)
      ALU_INC_SAT: begin
        rsp.res = (inc > DIST_W'(DEPTH_MAX)) ? DIST_W'(DEPTH_MAX) : inc;
      end
      ALU_LIFT_GE: begin
        rsp.flag = (LIFT_W'(req.x) >= thr);
      end
      ALU_GT: begin
        rsp.flag = (req.x > req.y);
      end
      ALU_DIST: begin
        if (sum[SUM_W-1]) begin
          rsp.res = '0;
        end else if (sum > SUM_W'(DIST_MAX)) begin
          rsp.res = DIST_MAX;
        end else begin
          rsp.res = sum[DIST_W-1:0];
        end
      end
    endcase
  end

endmodule

// ===== rtl/lca_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA sequencer
// Steps one transaction through index reduction, then table fill or lifting and distance.
// ----------------------------------------------------------------------------
module lca_seq import lca_pkg::*; #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10,
  localparam int IW  = $clog2(NODES),
  localparam int LW  = $clog2(LEVELS),
  localparam int AAW = IW + LW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  output logic [NODE_W-1:0]  idx_raw,
  input  logic [IW-1:0]      idx,
  output logic               dep_we,
  output logic [IW-1:0]      dep_waddr,
  output logic [DEPTH_W-1:0] dep_wdata,
  output logic [IW-1:0]      dep_raddr,
  input  logic [DEPTH_W-1:0] dep_rdata,
  output logic               anc_we,
  output logic [AAW-1:0]     anc_waddr,
  output logic [IW-1:0]      anc_wdata,
  output logic [AAW-1:0]     anc_raddr,
  input  logic [IW-1:0]      anc_rdata,
  output alu_req_t           alu_req,
  input  alu_rsp_t           alu_rsp
);

  localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               cmd_r, cmd_nxt;
  logic [NODE_W-1:0]  raw_a_r, raw_a_nxt;
  logic [NODE_W-1:0]  raw_b_r, raw_b_nxt;
  logic [IW-1:0]      na_r, na_nxt;
  logic [IW-1:0]      nb_r, nb_nxt;
  logic [IW-1:0]      ca_r, ca_nxt;
  logic [IW-1:0]      cb_r, cb_nxt;
  logic [IW-1:0]      xa_r, xa_nxt;
  logic [DEPTH_W-1:0] da_r, da_nxt;
  logic [DEPTH_W-1:0] db_r, db_nxt;
  logic [DEPTH_W-1:0] da0_r, da0_nxt;
  logic [DEPTH_W-1:0] dep_r, dep_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic               dz_r;
  logic               az_r;
  logic [DEPTH_W-1:0] dq;
  logic [IW-1:0]      aq;

  // Node 0 is the sentinel: its depth and ancestors always read as zero.
  assign dq = dz_r ? '0 : dep_rdata;
  assign aq = az_r ? '0 : anc_rdata;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RED_A;
        end
      end
      S_RED_A:   state_nxt = S_RED_B;
      S_RED_B:   state_nxt = S_CAP_A;
      S_CAP_A:   state_nxt = S_CAP_B;
      S_CAP_B:   state_nxt = (cmd_r == CMD_QUERY) ? S_Q_DA : S_ADD_DEP;
      S_ADD_DEP: state_nxt = (na_r == '0) ? S_FIN : S_ADD_INC;
      S_ADD_INC: state_nxt = S_ADD_RD;
      S_ADD_RD:  state_nxt = S_ADD_WR;
      S_ADD_WR:  state_nxt = (lvl_r == LAST) ? S_FIN : S_ADD_RD;
      S_Q_DA:    state_nxt = S_Q_DB;
      S_Q_DB:    state_nxt = S_Q_SW;
      S_Q_SW:    state_nxt = S_L1_CHK;
      S_L1_CHK: begin
        if (alu_rsp.flag) begin
          state_nxt = S_L1_ANC;
        end else if (lvl_r == '0) begin
          state_nxt = S_L1_END;
        end
      end
      S_L1_ANC:  state_nxt = S_L1_DEP;
      S_L1_DEP:  state_nxt = (lvl_r == '0) ? S_L1_END : S_L1_CHK;
      S_L1_END:  state_nxt = (ca_r == cb_r) ? S_Q_DC : S_L2_RA;
      S_L2_RA:   state_nxt = S_L2_RB;
      S_L2_RB:   state_nxt = S_L2_CMP;
      S_L2_CMP:  state_nxt = (lvl_r == '0) ? S_L2_FIN : S_L2_RA;
      S_L2_FIN:  state_nxt = S_L2_PAR;
      S_L2_PAR:  state_nxt = S_Q_DC;
      S_Q_DC:    state_nxt = S_Q_DIST;
      S_Q_DIST:  state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    raw_a_nxt     = raw_a_r;
    raw_b_nxt     = raw_b_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    ca_nxt        = ca_r;
    cb_nxt        = cb_r;
    xa_nxt        = xa_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    da0_nxt       = da0_r;
    dep_nxt       = dep_r;
    dist_nxt      = dist_r;
    lvl_nxt       = lvl_r;
    idx_raw       = raw_a_r;
    dep_we        = 1'b0;
    dep_waddr     = na_r;
    dep_wdata     = alu_rsp.res[DEPTH_W-1:0];
    dep_raddr     = '0;
    anc_we        = 1'b0;
    anc_waddr     = {na_r, lvl_r};
    anc_wdata     = aq;
    anc_raddr     = '0;
    alu_req.op    = ALU_INC_SAT;
    alu_req.x     = dq;
    alu_req.y     = da_r;
    alu_req.z     = dq;
    alu_req.lvl   = LVL_W'(lvl_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          raw_a_nxt = in_data.node_a;
          raw_b_nxt = in_data.node_b;
        end
      end
      S_RED_A: idx_raw = raw_a_r;
      S_RED_B: idx_raw = raw_b_r;
      S_CAP_A: na_nxt = idx;
      S_CAP_B: nb_nxt = idx;
      S_ADD_DEP: begin
        dep_raddr = nb_r;
        dep_nxt   = '0;
      end
      S_ADD_INC: begin
        alu_req.op = ALU_INC_SAT;
        alu_req.x  = dq;
        dep_we     = 1'b1;
        dep_waddr  = na_r;
        dep_wdata  = alu_rsp.res[DEPTH_W-1:0];
        dep_nxt    = alu_rsp.res[DEPTH_W-1:0];
        anc_we     = 1'b1;
        anc_waddr  = {na_r, LW'(0)};
        anc_wdata  = nb_r;
        cb_nxt     = nb_r;
        lvl_nxt    = LW'(1);
      end
      S_ADD_RD: begin
        anc_raddr = {cb_r, lvl_r - LW'(1)};
      end
      S_ADD_WR: begin
        anc_we    = 1'b1;
        anc_waddr = {na_r, lvl_r};
        anc_wdata = aq;
        cb_nxt    = aq;
        lvl_nxt   = lvl_r + LW'(1);
      end
      S_Q_DA: begin
        dep_raddr = na_r;
      end
      S_Q_DB: begin
        da_nxt    = dq;
        dep_raddr = nb_r;
      end
      S_Q_SW: begin
        alu_req.op = ALU_GT;
        alu_req.x  = dq;
        alu_req.y  = da_r;
        lvl_nxt    = LAST;
        if (alu_rsp.flag) begin
          ca_nxt  = nb_r;
          cb_nxt  = na_r;
          da_nxt  = dq;
          db_nxt  = da_r;
          da0_nxt = dq;
        end else begin
          ca_nxt  = na_r;
          cb_nxt  = nb_r;
          db_nxt  = dq;
          da0_nxt = da_r;
        end
      end
      S_L1_CHK: begin
        alu_req.op = ALU_LIFT_GE;
        alu_req.x  = da_r;
        alu_req.y  = db_r;
        anc_raddr  = {ca_r, lvl_r};
        if (!alu_rsp.flag) begin
          lvl_nxt = lvl_r - LW'(1);
        end
      end
      S_L1_ANC: begin
        ca_nxt    = aq;
        dep_raddr = aq;
      end
      S_L1_DEP: begin
        da_nxt  = dq;
        lvl_nxt = lvl_r - LW'(1);
      end
      S_L1_END: begin
        lvl_nxt = LAST;
      end
      S_L2_RA: begin
        anc_raddr = {ca_r, lvl_r};
      end
      S_L2_RB: begin
        xa_nxt    = aq;
        anc_raddr = {cb_r, lvl_r};
      end
      S_L2_CMP: begin
        if (xa_r != aq) begin
          ca_nxt = xa_r;
          cb_nxt = aq;
        end
        lvl_nxt = lvl_r - LW'(1);
      end
      S_L2_FIN: begin
        anc_raddr = {ca_r, LW'(0)};
      end
      S_L2_PAR: begin
        ca_nxt = aq;
      end
      S_Q_DC: begin
        dep_raddr = ca_r;
      end
      S_Q_DIST: begin
        alu_req.op = ALU_DIST;
        alu_req.x  = da0_r;
        alu_req.y  = db_r;
        alu_req.z  = dq;
        dist_nxt   = alu_rsp.res;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.is_answer  = cmd_r;
          out_data_nxt.ancestor   = (cmd_r == CMD_QUERY) ? NODE_W'(ca_r) : '0;
          out_data_nxt.distance   = (cmd_r == CMD_QUERY) ? dist_r : '0;
          out_data_nxt.node_depth = (cmd_r == CMD_QUERY) ? '0 : dep_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cmd_r      <= cmd_nxt;
    raw_a_r    <= raw_a_nxt;
    raw_b_r    <= raw_b_nxt;
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    xa_r       <= xa_nxt;
    da_r       <= da_nxt;
    db_r       <= db_nxt;
    da0_r      <= da0_nxt;
    dep_r      <= dep_nxt;
    dist_r     <= dist_nxt;
    lvl_r      <= lvl_nxt;
    dz_r       <= (dep_raddr == '0);
    az_r       <= (anc_raddr[AAW-1:LW] == '0);
  end

endmodule

// ===== rtl/tree_lca_distance_query_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree LCA distance query unit
// Binary-lifting lowest common ancestor and path distance over a stored tree.
// ----------------------------------------------------------------------------
// The unit takes one transaction at a time and holds in_stall high until its
// result has been placed in the output register, which then waits for the
// consumer while the next transaction is accepted. An add fills the ancestor
// table one level at a time; how long a query takes depends on how many
// levels are lifted. Both are paced by the single read port of the ancestor
// table and of the depth store, each lifting step waiting for its registered
// read. Node 0 is the sentinel and always reads as depth 0 with all
// ancestors 0, so no clearing pass runs after reset. Nodes must be added
// parent first.
// ----------------------------------------------------------------------------
module tree_lca_distance_query_unit import lca_pkg::*; #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IW  = $clog2(NODES);
  localparam int LW  = $clog2(LEVELS);
  localparam int AAW = IW + LW;

  logic [NODE_W-1:0]  idx_raw;
  logic [IW-1:0]      idx;
  logic               dep_we;
  logic [IW-1:0]      dep_waddr;
  logic [DEPTH_W-1:0] dep_wdata;
  logic [IW-1:0]      dep_raddr;
  logic [DEPTH_W-1:0] dep_rdata;
  logic               anc_we;
  logic [AAW-1:0]     anc_waddr;
  logic [IW-1:0]      anc_wdata;
  logic [AAW-1:0]     anc_raddr;
  logic [IW-1:0]      anc_rdata;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  lca_idx #(
    .NODES(NODES)
  ) u_idx (
    .clk(clk),
    .raw(idx_raw),
    .idx(idx)
  );

  lca_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  lca_ram #(
    .WIDTH(DEPTH_W),
    .DEPTH(NODES)
  ) u_depth_ram (
    .clk  (clk),
    .we   (dep_we),
    .waddr(dep_waddr),
    .wdata(dep_wdata),
    .raddr(dep_raddr),
    .rdata(dep_rdata)
  );

  lca_ram #(
    .WIDTH(IW),
    .DEPTH(NODES << LW)
  ) u_anc_ram (
    .clk  (clk),
    .we   (anc_we),
    .waddr(anc_waddr),
    .wdata(anc_wdata),
    .raddr(anc_raddr),
    .rdata(anc_rdata)
  );

  lca_seq #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .idx_raw  (idx_raw),
    .idx      (idx),
    .dep_we   (dep_we),
    .dep_waddr(dep_waddr),
    .dep_wdata(dep_wdata),
    .dep_raddr(dep_raddr),
    .dep_rdata(dep_rdata),
    .anc_we   (anc_we),
    .anc_waddr(anc_waddr),
    .anc_wdata(anc_wdata),
    .anc_raddr(anc_raddr),
    .anc_rdata(anc_rdata),
    .alu_req  (alu_req),
    .alu_rsp  (alu_rsp)
  );

endmodule
